FILE: hdl/lidar_frame_parser_binner_defines.svh
// assertion macros shared by the lidar frame parser checkers
`ifndef LIDAR_FRAME_PARSER_BINNER_DEFINES_SVH
`define LIDAR_FRAME_PARSER_BINNER_DEFINES_SVH

// same-cycle implication, held off while in reset
`define LFPB_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define LFPB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lfpb_pkg.sv
// shared types and constants of the lidar frame parser
package lfpb_pkg;

  // fixed frame layout before the point block
  localparam int LAST_HEADER_POS = 2;
  localparam int POS_START_HIGH  = 5;
  localparam int POS_START_LOW   = 6;
  localparam int POINTS_START    = 7;

  // angle constants, start/end angles in 1/100 degree, bins in 1/800 degree
  localparam logic [19:0] FULL_TURN      = 20'd288000;
  localparam logic [15:0] WRAP_START_MIN = 16'd35000;
  localparam logic [15:0] WRAP_END_MAX   = 16'd1300;
  localparam logic [16:0] TURN_RAW       = 17'd36000;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_LENGTH        = 2'd2
  } lfpb_reg_t;

  typedef struct packed {
    logic sum_clear;
    logic sum_add;
    logic start_hi;
    logic start_lo;
    logic end_hi;
    logic end_lo;
    logic dist_hi;
    logic mem_rd;
    logic mem_wr;
    logic mem_acc;
    logic emit_init;
    logic emit_calc;
    logic emit_load;
    logic emit_last;
    logic err_load;
  } lfpb_cmd_t;

  typedef struct packed {
    logic hdr_first_ok;
    logic hdr_second_ok;
    logic length_ok;
    logic sum_ok;
    logic out_free;
  } lfpb_status_t;

endpackage

FILE: hdl/lfpb_ctrl.sv
// controller: frame position tracking and bin emission sequencing
module lfpb_ctrl #(
  parameter int POINTS_PER_FRAME = 16,
  parameter int BIN_COUNT        = 8,
  parameter int BIN_W            = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lfpb_pkg::lfpb_status_t status,
  output lfpb_pkg::lfpb_cmd_t  cmd,
  output logic [BIN_W-1:0]     bin_sel
);
  import lfpb_pkg::*;

  localparam int END_HIGH_POS = POINTS_START + 3 * POINTS_PER_FRAME;
  localparam int CHECK_POS    = END_HIGH_POS + 2;
  localparam int POS_W        = $clog2(CHECK_POS + 1);
  localparam int P_W          = $clog2(POINTS_PER_FRAME);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_ERR  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    PH_HIGH = 3'b001,
    PH_LOW  = 3'b010,
    PH_INT  = 3'b100
  } phase_t;

  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [P_W-1:0]    pnt, pnt_next;
  logic [BIN_W-1:0]  bin, bin_next;
  logic [P_W:0]      bin_wide;
  logic              in_bins;
  logic              hdr_ok;
  logic              accept;
  logic              in_points;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && (state == ST_IDLE);
  assign bin_wide  = {1'b0, pnt} >> 1;
  assign in_bins   = (int'(bin_wide) < BIN_COUNT);
  assign bin_sel   = (state == ST_IDLE) ? BIN_W'(bin_wide) : bin;
  assign in_points = (pos >= POS_W'(POINTS_START)) && (pos < POS_W'(END_HIGH_POS));
  assign hdr_ok    = (pos == POS_W'(0)) ? status.hdr_first_ok :
                     (pos == POS_W'(1)) ? status.hdr_second_ok : status.length_ok;

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    pos_next   = pos;
    pnt_next   = pnt;
    bin_next   = bin;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (pos <= POS_W'(LAST_HEADER_POS)) begin
            // a wrong header byte restarts without being rechecked
            if (hdr_ok) begin
              cmd.sum_add = 1'b1;
              pos_next    = pos + POS_W'(1);
            end else begin
              cmd.sum_clear = 1'b1;
              pos_next      = '0;
            end
          end else if (pos == POS_W'(CHECK_POS)) begin
            cmd.sum_clear = 1'b1;
            pos_next      = '0;
            if (status.sum_ok) begin
              cmd.emit_init = 1'b1;
              bin_next      = '0;
              state_next    = ST_CALC;
            end else begin
              state_next = ST_ERR;
            end
          end else begin
            cmd.sum_add = 1'b1;
            pos_next    = pos + POS_W'(1);
            if (pos == POS_W'(POS_START_HIGH)) cmd.start_hi = 1'b1;
            if (pos == POS_W'(POS_START_LOW)) begin
              cmd.start_lo = 1'b1;
              pnt_next     = '0;
              phase_next   = PH_HIGH;
            end
            if (pos == POS_W'(END_HIGH_POS)) cmd.end_hi = 1'b1;
            if (pos == POS_W'(END_HIGH_POS + 1)) cmd.end_lo = 1'b1;
            if (in_points) begin
              unique case (phase)
                PH_HIGH: begin
                  cmd.dist_hi = 1'b1;
                  // fetch the bin sum now so the low byte can accumulate
                  cmd.mem_rd  = in_bins;
                  phase_next  = PH_LOW;
                end
                PH_LOW: begin
                  cmd.mem_wr  = in_bins;
                  cmd.mem_acc = pnt[0];
                  phase_next  = PH_INT;
                end
                PH_INT: begin
                  pnt_next   = pnt + P_W'(1);
                  phase_next = PH_HIGH;
                end
                default: phase_next = PH_HIGH;
              endcase
            end
          end
        end
      end
      ST_CALC: begin
        cmd.emit_calc = 1'b1;
        state_next    = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_last = (bin == BIN_LAST);
          if (bin == BIN_LAST) begin
            state_next = ST_IDLE;
          end else begin
            bin_next   = bin + BIN_W'(1);
            state_next = ST_CALC;
          end
        end
      end
      ST_ERR: begin
        if (status.out_free) begin
          cmd.err_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_HIGH;
      pos   <= '0;
      pnt   <= '0;
      bin   <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      pos   <= pos_next;
      pnt   <= pnt_next;
      bin   <= bin_next;
    end
  end

endmodule

FILE: hdl/lfpb_dp.sv
// datapath: config registers, checksum, bin sum memory, angle math, result register
module lfpb_dp #(
  parameter int POINTS_PER_FRAME = 16,
  parameter int BIN_COUNT        = 8,
  parameter int BIN_W            = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic [7:0]             rx_byte,
  input  lfpb_pkg::lfpb_cmd_t    cmd,
  input  logic [BIN_W-1:0]       bin_sel,
  output lfpb_pkg::lfpb_status_t status,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [19:0]            bin_angle,
  output logic [15:0]            bin_distance,
  output logic [2:0]             bin_number,
  output logic                   checksum_error,
  output logic                   last_of_frame
);
  import lfpb_pkg::*;

  // S*(B-m) + E*m stays below B * 2^17
  localparam int NUM_W  = 17 + $clog2(BIN_COUNT);
  localparam int X_W    = NUM_W + 3;
  // reciprocal precision: x * error < 2^K keeps the quotient exact
  localparam int K      = X_W + $clog2(BIN_COUNT) + 1;
  localparam int R_W    = K + 1;
  localparam int PROD_W = X_W + R_W;
  localparam longint unsigned RECIP_L = ((64'd1 << K) + BIN_COUNT - 1) / BIN_COUNT;
  localparam logic [R_W-1:0] RECIP_V = R_W'(RECIP_L);

  logic [7:0]        hdr_first, hdr_second, length_val;
  logic [7:0]        running_sum;
  logic [15:0]       start_raw;
  logic [7:0]        end_hi, end_lo, dist_hi;
  logic [16:0]       pair_mem [BIN_COUNT];
  logic [16:0]       rd_data;
  logic [16:0]       acc_value;
  logic [15:0]       end_raw;
  logic [16:0]       e_adj;
  logic [NUM_W-1:0]  num;
  logic [X_W-1:0]    num_x;
  logic [PROD_W-1:0] prod;
  logic [19:0]       ang_q, ang_w;
  logic              has_pts;
  logic [15:0]       dist_w;

  assign status.hdr_first_ok  = (rx_byte == hdr_first);
  assign status.hdr_second_ok = (rx_byte == hdr_second);
  assign status.length_ok     = (rx_byte == length_val);
  assign status.sum_ok        = (rx_byte == running_sum);
  assign status.out_free      = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_first  <= 8'd170;
      hdr_second <= 8'd85;
      length_val <= 8'd44;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  hdr_first  <= cfg_data;
        REG_HEADER_SECOND: hdr_second <= cfg_data;
        REG_LENGTH:        length_val <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (cmd.sum_clear) begin
      running_sum <= '0;
    end else if (cmd.sum_add) begin
      running_sum <= running_sum + rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_hi) start_raw[15:8] <= rx_byte;
    if (cmd.start_lo) start_raw[7:0]  <= rx_byte;
    if (cmd.end_hi)   end_hi          <= rx_byte;
    if (cmd.end_lo)   end_lo          <= rx_byte;
    if (cmd.dist_hi)  dist_hi         <= rx_byte;
  end

  // the first point of a bin overwrites, the second adds to it
  assign acc_value = (cmd.mem_acc ? rd_data : 17'd0) + {1'b0, dist_hi, rx_byte};

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) pair_mem[bin_sel] <= acc_value;
    if (cmd.mem_rd || cmd.emit_calc) rd_data <= pair_mem[bin_sel];
  end

  assign end_raw = {end_hi, end_lo};
  assign num_x   = {num, 3'b000};

  // num walks from S*B in steps of E - S, one step per bin
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      if (start_raw > WRAP_START_MIN && end_raw < WRAP_END_MAX) begin
        e_adj <= {1'b0, end_raw} + TURN_RAW;
      end else begin
        e_adj <= {1'b0, end_raw};
      end
      num <= NUM_W'(start_raw * BIN_COUNT);
    end else if (cmd.emit_load) begin
      num <= num + NUM_W'(e_adj) - NUM_W'(start_raw);
    end
    if (cmd.emit_calc) prod <= PROD_W'(num_x) * PROD_W'(RECIP_V);
  end

  assign ang_q   = prod[K +: 20];
  assign ang_w   = (ang_q > FULL_TURN) ? ang_q - FULL_TURN : ang_q;
  assign has_pts = (int'({bin_sel, 1'b0}) < POINTS_PER_FRAME);
  assign dist_w  = has_pts ? rd_data[16:1] : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.err_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      bin_angle      <= ang_w;
      bin_distance   <= dist_w;
      bin_number     <= 3'(bin_sel);
      checksum_error <= 1'b0;
      last_of_frame  <= cmd.emit_last;
    end else if (cmd.err_load) begin
      bin_angle      <= '0;
      bin_distance   <= '0;
      bin_number     <= '0;
      checksum_error <= 1'b1;
      last_of_frame  <= 1'b1;
    end
  end

endmodule

FILE: hdl/lidar_frame_parser_binner.sv
// top level of the lidar serial frame parser and point binner
//
//   channel  direction  handshake              payload
//   config   in         cfg_write              cfg_index, cfg_data
//   input    in         in_valid / in_stall    rx_byte
//   output   out        out_valid / out_stall  bin_angle, bin_distance, bin_number,
//                                              checksum_error, last_of_frame
//
// every byte is taken without a stall while the parser is between checksum bytes
// a good checksum byte stalls input while each bin passes through ST_CALC, for the
// bin memory read and reciprocal multiply, and ST_LOAD, to load the result
// a bad checksum byte stalls input in ST_ERR until the error result loads
// out_stall holds the sequencer until the result register frees up
// rst is synchronous and loads the default header values; the bin memory needs no clear
module lidar_frame_parser_binner #(
  parameter int POINTS_PER_FRAME = 16,
  parameter int BIN_COUNT        = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] bin_angle,
  output logic [15:0] bin_distance,
  output logic [2:0]  bin_number,
  output logic        checksum_error,
  output logic        last_of_frame
);
  import lfpb_pkg::*;

  localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  lfpb_cmd_t        cmd;
  lfpb_status_t     status;
  logic [BIN_W-1:0] bin_sel;

  lfpb_ctrl #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .BIN_COUNT(BIN_COUNT),
    .BIN_W(BIN_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status(status),
    .cmd(cmd),
    .bin_sel(bin_sel)
  );

  lfpb_dp #(
    .POINTS_PER_FRAME(POINTS_PER_FRAME),
    .BIN_COUNT(BIN_COUNT),
    .BIN_W(BIN_W)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rx_byte(rx_byte),
    .cmd(cmd),
    .bin_sel(bin_sel),
    .status(status),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .bin_angle(bin_angle),
    .bin_distance(bin_distance),
    .bin_number(bin_number),
    .checksum_error(checksum_error),
    .last_of_frame(last_of_frame)
  );

endmodule

FILE: hdl/lfpb_checker.sv
// port-level checker for the lidar frame parser, bound to the top level
`include "lidar_frame_parser_binner_defines.svh"

module lfpb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] bin_angle,
  input logic [15:0] bin_distance,
  input logic [2:0]  bin_number,
  input logic        checksum_error,
  input logic        last_of_frame
);

  // error result: no angle, distance or bin number, error and last set
  localparam logic [40:0] ERR_PAYLOAD = {20'd0, 16'd0, 3'd0, 1'b1, 1'b1};

  logic        out_held;
  logic        err_shown;
  logic        in_take;
  logic [40:0] payload;

  assign out_held  = out_valid && out_stall;
  assign err_shown = out_valid && checksum_error;
  assign in_take   = in_valid && !in_stall;
  assign payload   = {bin_angle, bin_distance, bin_number, checksum_error, last_of_frame};

  `LFPB_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid, "result dropped while stalled")
  `LFPB_ASSERT_NEXT(a_out_stable, clk, rst, out_held, $stable(payload), "stalled result changed")
  `LFPB_ASSERT_IMP(a_err_form, clk, rst, err_shown, payload == ERR_PAYLOAD, "malformed error result")
  `LFPB_ASSERT_IMP(a_stall_cause, clk, rst, $rose(in_stall), $past(in_take), "stall without transfer")

endmodule

bind lidar_frame_parser_binner lfpb_checker u_lfpb_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .bin_angle(bin_angle),
  .bin_distance(bin_distance),
  .bin_number(bin_number),
  .checksum_error(checksum_error),
  .last_of_frame(last_of_frame)
);

FILE: test/lidar_frame_parser_binner_test.sv
// self-checking testbench for the lidar frame parser and point binner
`timescale 1ns / 1ps

module lidar_frame_parser_binner_test;
  import lfpb_pkg::*;

  localparam int POINTS    = 16;
  localparam int BIN_TOTAL = 8;
  localparam int END_POS   = POINTS_START + 3 * POINTS;
  localparam int CHECK_POS = END_POS + 2;
  localparam int FRAME_LEN = CHECK_POS + 1;
  // the checksum byte keeps the block busy while it computes and loads each bin
  localparam int TAIL      = 2 * BIN_TOTAL + 4;
  localparam int LIMIT     = 500000;
  // index past the register list, the block drops the write
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [19:0] angle;
    logic [15:0] distance;
    logic [2:0]  num;
    logic        err;
    logic        last;
  } bin_rec_t;

  localparam bin_rec_t SUM_ERROR_REC = '{angle: 20'd0, distance: 16'd0, num: 3'd0,
                                         err: 1'b1, last: 1'b1};

  typedef enum logic [1:0] {ROW_BYTE, ROW_FRAME, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, SUM_ERROR} row_check_t;
  typedef enum logic [1:0] {D_ZERO, D_MAX, D_RAMP, D_RANDOM} dist_mode_t;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} stall_mode_t;

  typedef struct packed {
    row_kind_t   kind;
    row_check_t  chk;
    logic [1:0]  idx;
    logic [7:0]  data;
    logic [15:0] sa;
    logic [15:0] ea;
    dist_mode_t  dm;
    logic        bad;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [19:0] bin_angle;
  logic [15:0] bin_distance;
  logic [2:0]  bin_number;
  logic        checksum_error;
  logic        last_of_frame;

  lidar_frame_parser_binner #(
    .POINTS_PER_FRAME(POINTS),
    .BIN_COUNT(BIN_TOTAL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bin_angle(bin_angle),
    .bin_distance(bin_distance),
    .bin_number(bin_number),
    .checksum_error(checksum_error),
    .last_of_frame(last_of_frame)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state as the testbench sees it
  logic [7:0]  want_first = 8'd170;
  logic [7:0]  want_second = 8'd85;
  logic [7:0]  want_length = 8'd44;
  int unsigned frame_pos = 0;
  logic [7:0]  byte_sum = 8'd0;
  logic [15:0] start_raw = 16'd0;
  logic [7:0]  end_hi = 8'd0;
  logic [7:0]  end_lo = 8'd0;
  logic [7:0]  dist_hi = 8'd0;
  logic [16:0] pair_sum [BIN_TOTAL];
  logic        byte_taken;

  bin_rec_t    fresh_bins [$];
  bin_rec_t    pending_bins [$];
  bin_rec_t    bin_head;
  plan_row_t   plan [$];
  logic [7:0]  frame_buf [FRAME_LEN];

  int          mismatches = 0;
  int          bytes_taken = 0;
  int          bins_predicted = 0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = RX_OPEN;

  function automatic void parse_byte(input logic [7:0] b);
    int unsigned pos, k, pt;
    logic [7:0] want;
    longint unsigned s, e, a;
    bin_rec_t rec;
    pos = frame_pos;
    byte_taken = 1'b1;
    if (pos <= LAST_HEADER_POS) begin
      want = (pos == 0) ? want_first : (pos == 1) ? want_second : want_length;
      if (b != want) begin
        // a bad header byte is dropped, not taken as a new first byte
        frame_pos = 0;
        byte_sum = 8'd0;
        byte_taken = 1'b0;
        return;
      end
      if (pos == 0) begin
        foreach (pair_sum[i]) pair_sum[i] = 17'd0;
        byte_sum = 8'd0;
      end
    end else if (pos == POS_START_HIGH) begin
      start_raw = {b, 8'h00};
    end else if (pos == POS_START_LOW) begin
      start_raw[7:0] = b;
    end else if (pos >= POINTS_START && pos < END_POS) begin
      k = pos - POINTS_START;
      pt = k / 3;
      if (k % 3 == 0) begin
        dist_hi = b;
      end else if (k % 3 == 1 && pt / 2 < BIN_TOTAL) begin
        pair_sum[pt / 2] = pair_sum[pt / 2] + {1'b0, dist_hi, b};
      end
    end else if (pos == END_POS) begin
      end_hi = b;
    end else if (pos == END_POS + 1) begin
      end_lo = b;
    end else if (pos == CHECK_POS) begin
      frame_pos = 0;
      if (byte_sum != b) begin
        byte_sum = 8'd0;
        fresh_bins.push_back(SUM_ERROR_REC);
        return;
      end
      byte_sum = 8'd0;
      s = 64'(start_raw);
      e = 64'({end_hi, end_lo});
      // start just before north, end just past it
      if (s > 64'(WRAP_START_MIN) && e < 64'(WRAP_END_MAX)) e = e + 64'(TURN_RAW);
      for (int m = 0; m < BIN_TOTAL; m++) begin
        a = (s * 64'(BIN_TOTAL - m) + e * 64'(m)) * 64'd8 / 64'(BIN_TOTAL);
        if (a > 64'(FULL_TURN)) a = a - 64'(FULL_TURN);
        rec.angle = a[19:0];
        rec.distance = pair_sum[m][16:1];
        rec.num = 3'(m);
        rec.err = 1'b0;
        rec.last = (m == BIN_TOTAL - 1);
        fresh_bins.push_back(rec);
      end
      return;
    end
    byte_sum = byte_sum + b;
    frame_pos = pos + 1;
  endfunction

  function automatic void build_frame(input logic [15:0] sa, input logic [15:0] ea,
                                      input dist_mode_t dm, input logic bad);
    logic [7:0]  sum;
    logic [15:0] d;
    int p, i;
    frame_buf[0] = want_first;
    frame_buf[1] = want_second;
    frame_buf[2] = want_length;
    frame_buf[3] = 8'($urandom);
    frame_buf[4] = 8'($urandom);
    frame_buf[POS_START_HIGH] = sa[15:8];
    frame_buf[POS_START_LOW] = sa[7:0];
    for (p = 0; p < POINTS; p++) begin
      case (dm)
        D_ZERO:  d = 16'h0000;
        D_MAX:   d = 16'hFFFF;
        D_RAMP:  d = 16'(p * 4099);
        default: d = 16'($urandom);
      endcase
      frame_buf[POINTS_START + 3 * p] = d[15:8];
      frame_buf[POINTS_START + 3 * p + 1] = d[7:0];
      frame_buf[POINTS_START + 3 * p + 2] = 8'($urandom);
    end
    frame_buf[END_POS] = ea[15:8];
    frame_buf[END_POS + 1] = ea[7:0];
    sum = 8'd0;
    for (i = 0; i < CHECK_POS; i++) sum = sum + frame_buf[i];
    frame_buf[CHECK_POS] = bad ? sum + 8'($urandom_range(1, 255)) : sum;
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 1299));
      1:       return 16'($urandom_range(35001, 65535));
      2:       return 16'($urandom_range(0, 36000));
      3:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_reg_value(input logic [7:0] dflt);
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return dflt;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic trust_model);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b);
    if (byte_taken) bytes_taken++;
    if (trust_model) begin
      while (fresh_bins.size() != 0) begin
        pending_bins.push_back(fresh_bins.pop_front());
        bins_predicted++;
      end
    end else begin
      fresh_bins.delete();
    end
  endtask

  task automatic send_frame(input logic [15:0] sa, input logic [15:0] ea, input dist_mode_t dm,
                            input logic bad, input int len, input logic trust_model);
    int i;
    build_frame(sa, ea, dm, bad);
    for (i = 0; i < len; i++) send_byte(frame_buf[i], trust_model);
  endtask

  // hold the sender until every bin is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_HEADER_FIRST:  want_first = v;
      REG_HEADER_SECOND: want_second = v;
      REG_LENGTH:        want_length = v;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [19:0] want, input logic [19:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_bins.size() == 0) begin
        flag_mismatch("result with none pending, bin_angle", 20'd0, bin_angle);
      end else begin
        bin_head = pending_bins.pop_front();
        if (bin_head.angle !== bin_angle) flag_mismatch("bin_angle", bin_head.angle, bin_angle);
        if (bin_head.distance !== bin_distance)
          flag_mismatch("bin_distance", 20'(bin_head.distance), 20'(bin_distance));
        if (bin_head.num !== bin_number)
          flag_mismatch("bin_number", 20'(bin_head.num), 20'(bin_number));
        if (bin_head.err !== checksum_error)
          flag_mismatch("checksum_error", 20'(bin_head.err), 20'(checksum_error));
        if (bin_head.last !== last_of_frame)
          flag_mismatch("last_of_frame", 20'(bin_head.last), 20'(last_of_frame));
      end
    end
  end

  // receiver back-pressure, switching between patterns every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= (cycle_count % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int base_bytes, base_bins, pick;
    dist_mode_t dm;
    foreach (pair_sum[i]) pair_sum[i] = 17'd0;

    // header handling with the reset values
    plan.push_back('{ROW_BYTE, NO_RESULT, REG_HEADER_FIRST, 8'h00, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_BYTE, BY_MODEL, REG_HEADER_FIRST, 8'd170, 16'd0, 16'd0, D_ZERO, 1'b0});
    // first header again in second place resets, and is not taken as a new start
    plan.push_back('{ROW_BYTE, NO_RESULT, REG_HEADER_FIRST, 8'd170, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_BYTE, NO_RESULT, REG_HEADER_FIRST, 8'd85, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_BYTE, BY_MODEL, REG_HEADER_FIRST, 8'd170, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_BYTE, BY_MODEL, REG_HEADER_FIRST, 8'd85, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_BYTE, NO_RESULT, REG_HEADER_FIRST, 8'hFF, 16'd0, 16'd0, D_ZERO, 1'b0});
    // angle and distance extremes, wrap fix on and just off, exact full turn
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'hFFFF, 16'hFFFF, D_MAX,
                     1'b0});
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'd35001, 16'd1299, D_RAMP,
                     1'b0});
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'd35000, 16'd1299, D_RAMP,
                     1'b0});
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'd35001, 16'd1300, D_RANDOM,
                     1'b0});
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'd36000, 16'd36000, D_RAMP,
                     1'b0});
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'hFFFF, 16'd0, D_MAX, 1'b0});
    plan.push_back('{ROW_FRAME, SUM_ERROR, REG_HEADER_FIRST, 8'd0, 16'd1000, 16'd2000, D_RANDOM,
                     1'b1});
    // register extremes and a write past the register list
    plan.push_back('{ROW_CFG, BY_MODEL, REG_HEADER_FIRST, 8'h00, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_CFG, BY_MODEL, REG_HEADER_SECOND, 8'hFF, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_CFG, BY_MODEL, REG_LENGTH, 8'hFF, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_CFG, BY_MODEL, REG_UNUSED, 8'h12, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'd12345, 16'd23456, D_RANDOM,
                     1'b0});
    plan.push_back('{ROW_FRAME, SUM_ERROR, REG_HEADER_FIRST, 8'd0, 16'd0, 16'd0, D_ZERO, 1'b1});
    plan.push_back('{ROW_CFG, BY_MODEL, REG_HEADER_FIRST, 8'hFF, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_CFG, BY_MODEL, REG_HEADER_SECOND, 8'h00, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_CFG, BY_MODEL, REG_LENGTH, 8'h00, 16'd0, 16'd0, D_ZERO, 1'b0});
    plan.push_back('{ROW_FRAME, BY_MODEL, REG_HEADER_FIRST, 8'd0, 16'd35999, 16'd0, D_RANDOM,
                     1'b0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      case (plan[r].kind)
        ROW_BYTE: begin
          send_byte(plan[r].data, plan[r].chk == BY_MODEL);
        end
        ROW_FRAME: begin
          send_frame(plan[r].sa, plan[r].ea, plan[r].dm, plan[r].bad, FRAME_LEN,
                     plan[r].chk == BY_MODEL);
          if (plan[r].chk == SUM_ERROR) pending_bins.push_back(SUM_ERROR_REC);
        end
        default: begin
          settle();
          write_reg(plan[r].idx, plan[r].data);
        end
      endcase
    end

    base_bytes = bytes_taken;
    base_bins = bins_predicted;
    while (bytes_taken - base_bytes < 230 || bins_predicted - base_bins < 48) begin
      settle();
      if ($urandom_range(0, 2) != 0) write_reg(REG_HEADER_FIRST, pick_reg_value(8'd170));
      if ($urandom_range(0, 2) != 0) write_reg(REG_HEADER_SECOND, pick_reg_value(8'd85));
      if ($urandom_range(0, 2) != 0) write_reg(REG_LENGTH, pick_reg_value(8'd44));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 8'($urandom));
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 99);
        dm = ($urandom_range(0, 3) == 0) ? dist_mode_t'($urandom_range(0, 2)) : D_RANDOM;
        // run out whatever partial frame the parser still holds
        if (pick < 85)
          while (frame_pos != 0) send_byte(8'($urandom), 1'b1);
        if (pick < 70)
          send_frame(pick_angle(), pick_angle(), dm, 1'b0, FRAME_LEN, 1'b1);
        else if (pick < 85)
          send_frame(pick_angle(), pick_angle(), dm, 1'b1, FRAME_LEN, 1'b1);
        else if (pick < 93)
          send_frame(pick_angle(), pick_angle(), dm, 1'b0, $urandom_range(1, FRAME_LEN - 1),
                     1'b1);
        else
          repeat ($urandom_range(1, 20)) send_byte(8'($urandom), 1'b1);
      end
    end

    settle();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
